### hdl/gnss_error_quality_grader_top_defines.svh
// Assertion macros used by the grader top level.
`ifndef GNSS_ERROR_QUALITY_GRADER_TOP_DEFINES_SVH
`define GNSS_ERROR_QUALITY_GRADER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GQG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GQG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GQG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GQG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/gqg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gqg_pkg;

  localparam int SIGMA_WIDTH_DEFAULT = 16;

  localparam int SQ_W    = 16;
  localparam int RAD_W   = 2 * SQ_W + 1;
  localparam int ROOT_W  = SQ_W + 1;
  localparam int STEPS   = ROOT_W;
  localparam int CNT_W   = $clog2(STEPS + 1);
  localparam int REM_W   = ROOT_W + 3;
  localparam int REG_W   = 15;
  localparam int GRADE_W = 3;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_LIMIT    = 2'd1;

  localparam logic [REG_W-1:0] LOCK_THRESHOLD_RESET = 15'd2560;
  localparam logic [REG_W-1:0] CLAMP_LIMIT_RESET    = 15'd25344;
  localparam logic [REG_W-1:0] LAST_RADIUS_RESET    = 15'd2560;
  localparam logic [REG_W-1:0] MIN_RADIUS_RESET     = 15'd25600;
  localparam logic [REG_W-1:0] MIN_FALLBACK         = 15'd1280;

  localparam logic [GRADE_W-1:0] GRADE_NONE      = 3'd0;
  localparam logic [GRADE_W-1:0] GRADE_POOR      = 3'd1;
  localparam logic [GRADE_W-1:0] GRADE_FAIR      = 3'd2;
  localparam logic [GRADE_W-1:0] GRADE_GOOD      = 3'd3;
  localparam logic [GRADE_W-1:0] GRADE_EXCELLENT = 3'd4;

  typedef struct packed {
    logic             lock_flag;
    logic [REG_W-1:0] last_radius;
    logic [REG_W-1:0] min_radius;
  } track_t;

endpackage

`default_nettype wire

### hdl/gqg_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module gqg_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [gqg_pkg::RAD_W-1:0]     radicand,
  output logic                               done,
  output logic [gqg_pkg::ROOT_W-1:0]         root
);

  localparam int RadW2 = 2 * gqg_pkg::STEPS;

  logic                           busy;
  logic [gqg_pkg::CNT_W-1:0]      cnt;
  logic [RadW2-1:0]               rad;
  logic [gqg_pkg::REM_W-1:0]      rem;
  logic [gqg_pkg::REM_W-1:0]      rem_sh;
  logic [gqg_pkg::REM_W-1:0]      trial;
  logic                           take;

  assign rem_sh = {rem[gqg_pkg::REM_W-3:0], rad[RadW2-1 -: 2]};
  assign trial  = gqg_pkg::REM_W'({root, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= gqg_pkg::CNT_W'(gqg_pkg::STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == gqg_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RadW2'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RadW2-3:0], 2'b00};
      if (take) begin
        rem  <= rem_sh - trial;
        root <= {root[gqg_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[gqg_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

### hdl/gqg_grade.sv
`timescale 1ns / 1ps
`default_nettype none

module gqg_grade (
  input  wire logic [gqg_pkg::ROOT_W-1:0]  radius,
  input  wire logic                        sat,
  input  wire gqg_pkg::track_t             cur,
  input  wire logic [gqg_pkg::REG_W-1:0]   lock_threshold,
  input  wire logic [gqg_pkg::REG_W-1:0]   clamp_limit,
  output gqg_pkg::track_t                  nxt,
  output logic [gqg_pkg::GRADE_W-1:0]      grade
);

  localparam int CmpW = gqg_pkg::REG_W + 5;

  logic [gqg_pkg::ROOT_W-1:0] r;
  logic [gqg_pkg::REG_W-1:0]  mn0;
  logic [gqg_pkg::REG_W-1:0]  last;
  logic [gqg_pkg::REG_W-1:0]  mn;
  logic [CmpW-1:0]            c;
  logic [CmpW-1:0]            m;

  always_comb begin
    r    = sat ? gqg_pkg::ROOT_W'(1 << gqg_pkg::SQ_W) : radius;
    mn0  = (cur.min_radius == '0) ? gqg_pkg::MIN_FALLBACK : cur.min_radius;
    last = cur.last_radius;
    if (r != '0) begin
      if (r < gqg_pkg::ROOT_W'(clamp_limit)) begin
        last = r[gqg_pkg::REG_W-1:0];
      end else begin
        last = clamp_limit;
      end
    end
    mn    = mn0;
    grade = gqg_pkg::GRADE_NONE;
    nxt.lock_flag   = cur.lock_flag;
    nxt.last_radius = last;
    if (!cur.lock_flag) begin
      if (last < lock_threshold) begin
        nxt.lock_flag = 1'b1;
        mn = last;
      end
    end else begin
      if (last < mn0) begin
        mn = last;
      end
    end
    nxt.min_radius = mn;
    c = CmpW'(last);
    m = CmpW'(mn);
    if (cur.lock_flag) begin
      if ((c << 1) < ((m << 1) + m)) begin
        grade = gqg_pkg::GRADE_EXCELLENT;
      end else if (c < (m << 2)) begin
        grade = gqg_pkg::GRADE_GOOD;
      end else if (c < (m << 3)) begin
        grade = gqg_pkg::GRADE_FAIR;
      end else if (c < ((m << 4) + (m << 2))) begin
        grade = gqg_pkg::GRADE_POOR;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/gnss_error_quality_grader_top.sv
// GNSS error quality grader.
// Input words carry the longitude and latitude error sigmas (Q8.8 metres)
// on a valid/ready channel; each accepted word yields exactly one output word
// with the grade, the clamped error radius, the best radius and the lock flag.
// The two sigmas are squared one after the other on a single 16 x 16
// multiplier, and the radius comes from a bit-serial square root that retires
// one root bit per cycle. A word then passes through the grading step into
// the output register, and a new word is taken only once its result has
// been written there.
// The output word sits in a register, and in_ready rises in the same cycle
// as out_valid. If the receiver stalls, the finished result waits in the
// grading step until the output register is free, and no new word is taken
// meanwhile.
// The configuration port writes the lock threshold (index 0) and the clamp
// limit (index 1); other indexes are ignored.
// Reset is synchronous and restores the default threshold of 10 m, the
// clamp of 99 m, the unlocked state, a radius of 10 m and a best of 100 m.
`timescale 1ns / 1ps
`default_nettype none
`include "gnss_error_quality_grader_top_defines.svh"

module gnss_error_quality_grader_top #(
  parameter int SIGMA_WIDTH = gqg_pkg::SIGMA_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [gqg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [gqg_pkg::REG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [SIGMA_WIDTH-1:0]            lon_sigma,
  input  wire logic [SIGMA_WIDTH-1:0]            lat_sigma,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [gqg_pkg::GRADE_W-1:0]            grade,
  output logic [gqg_pkg::REG_W-1:0]              error_radius,
  output logic [gqg_pkg::REG_W-1:0]              best_radius,
  output logic                                   locked
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_LON,
    ST_SQ_LAT,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t                          state;
  logic [gqg_pkg::REG_W-1:0]       lock_threshold;
  logic [gqg_pkg::REG_W-1:0]       clamp_limit;
  gqg_pkg::track_t                 track;
  gqg_pkg::track_t                 track_next;
  logic [gqg_pkg::GRADE_W-1:0]     grade_next;
  logic [gqg_pkg::SQ_W-1:0]        lon;
  logic [gqg_pkg::SQ_W-1:0]        lat;
  logic                            sat;
  logic [gqg_pkg::SQ_W-1:0]        mul_a;
  logic [2*gqg_pkg::SQ_W-1:0]      prod;
  logic [2*gqg_pkg::SQ_W-1:0]      acc;
  logic [gqg_pkg::RAD_W-1:0]       sum;
  logic                            sq_start;
  logic                            sq_done;
  logic [gqg_pkg::ROOT_W-1:0]      sq_root;
  logic                            out_free;

  assign in_ready = (state == ST_IDLE);
  assign mul_a    = (state == ST_SQ_LAT) ? lat : lon;
  assign prod     = mul_a * mul_a;
  assign sum      = gqg_pkg::RAD_W'(acc) + gqg_pkg::RAD_W'(prod);
  assign sq_start = (state == ST_SQ_LAT);
  assign out_free = !out_valid || out_ready;

  gqg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sum),
    .done     (sq_done),
    .root     (sq_root)
  );

  gqg_grade u_grade (
    .radius         (sq_root),
    .sat            (sat),
    .cur            (track),
    .lock_threshold (lock_threshold),
    .clamp_limit    (clamp_limit),
    .nxt            (track_next),
    .grade          (grade_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= gqg_pkg::LOCK_THRESHOLD_RESET;
      clamp_limit    <= gqg_pkg::CLAMP_LIMIT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        gqg_pkg::REG_LOCK_THRESHOLD: lock_threshold <= cfg_data;
        gqg_pkg::REG_CLAMP_LIMIT:    clamp_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      track.lock_flag   <= 1'b0;
      track.last_radius <= gqg_pkg::LAST_RADIUS_RESET;
      track.min_radius  <= gqg_pkg::MIN_RADIUS_RESET;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            lon   <= gqg_pkg::SQ_W'(lon_sigma);
            lat   <= gqg_pkg::SQ_W'(lat_sigma);
            sat   <= ((lon_sigma >> gqg_pkg::SQ_W) != '0) ||
                     ((lat_sigma >> gqg_pkg::SQ_W) != '0);
            state <= ST_SQ_LON;
          end
        end
        ST_SQ_LON: begin
          acc   <= prod;
          state <= ST_SQ_LAT;
        end
        ST_SQ_LAT: begin
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            track        <= track_next;
            grade        <= grade_next;
            error_radius <= track_next.last_radius;
            best_radius  <= track_next.min_radius;
            locked       <= track_next.lock_flag;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GQG_ASSERT_NEXT(a_lock_sticky, clk, rst, track.lock_flag, track.lock_flag)
  `GQG_ASSERT_IMP(a_done_in_sqrt, clk, rst, sq_done, state == ST_SQRT)
  `GQG_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

### tb/sv/gnss_error_quality_grader_checker.sv
`timescale 1ns / 1ps

module gnss_error_quality_grader_checker #(
  parameter int SIGMA_WIDTH = gqg_pkg::SIGMA_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [gqg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gqg_pkg::REG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [SIGMA_WIDTH-1:0]          lon_sigma,
  input  logic [SIGMA_WIDTH-1:0]          lat_sigma,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [gqg_pkg::GRADE_W-1:0]     grade,
  input  logic [gqg_pkg::REG_W-1:0]       error_radius,
  input  logic [gqg_pkg::REG_W-1:0]       best_radius,
  input  logic                            locked,
  output int                              fail_count,
  output int                              pending
);
  import gqg_pkg::*;

  typedef struct packed {
    logic [GRADE_W-1:0] grade;
    logic [REG_W-1:0]   error_radius;
    logic [REG_W-1:0]   best_radius;
    logic               locked;
  } fix_report_t;

  fix_report_t fix_reports_due[$];

  logic [REG_W-1:0] thr_reg;
  logic [REG_W-1:0] clamp_reg;
  logic             is_locked;
  logic [REG_W-1:0] radius_now;
  logic [REG_W-1:0] radius_best;

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Advances the tracking state by one sigma pair and returns the report it yields.
  function automatic fix_report_t grade_fix(input logic [SIGMA_WIDTH-1:0] lon,
                                            input logic [SIGMA_WIDTH-1:0] lat);
    fix_report_t     rep;
    longint unsigned l;
    longint unsigned a;
    longint unsigned r;
    longint unsigned cur;
    longint unsigned mn;
    l = lon;
    a = lat;
    if (l >= 64'd65536 || a >= 64'd65536) begin
      r = 64'd65536;
    end else begin
      r = root_floor(l * l + a * a);
    end
    if (radius_best == '0) begin
      radius_best = MIN_FALLBACK;
    end
    if (r > 0) begin
      if (r < clamp_reg) begin
        radius_now = r[REG_W-1:0];
      end else begin
        radius_now = clamp_reg;
      end
    end
    rep.grade = GRADE_NONE;
    if (!is_locked) begin
      if (radius_now < thr_reg) begin
        is_locked = 1'b1;
        radius_best = radius_now;
      end
    end else begin
      if (radius_now < radius_best) begin
        radius_best = radius_now;
      end
      cur = radius_now;
      mn = radius_best;
      if (cur * 2 < mn * 3) begin
        rep.grade = GRADE_EXCELLENT;
      end else if (cur < mn * 4) begin
        rep.grade = GRADE_GOOD;
      end else if (cur < mn * 8) begin
        rep.grade = GRADE_FAIR;
      end else if (cur < mn * 20) begin
        rep.grade = GRADE_POOR;
      end else begin
        rep.grade = GRADE_NONE;
      end
    end
    rep.error_radius = radius_now;
    rep.best_radius = radius_best;
    rep.locked = is_locked;
    return rep;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    fix_report_t due;
    if (rst) begin
      thr_reg = LOCK_THRESHOLD_RESET;
      clamp_reg = CLAMP_LIMIT_RESET;
      is_locked = 1'b0;
      radius_now = LAST_RADIUS_RESET;
      radius_best = MIN_RADIUS_RESET;
      fix_reports_due.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_index == REG_LOCK_THRESHOLD) begin
          thr_reg = cfg_data;
        end else if (cfg_index == REG_CLAMP_LIMIT) begin
          clamp_reg = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        if (fix_reports_due.size() == 0) begin
          $error("unexpected output word: grade %0d, error_radius %0d", grade, error_radius);
          fail_count <= fail_count + 1;
        end else begin
          due = fix_reports_due.pop_front();
          if (grade !== due.grade || error_radius !== due.error_radius ||
              best_radius !== due.best_radius || locked !== due.locked) begin
            fail_count <= fail_count + 1;
          end
          if (grade !== due.grade) begin
            $error("grade: expected %0d, got %0d", due.grade, grade);
          end
          if (error_radius !== due.error_radius) begin
            $error("error_radius: expected %0d, got %0d", due.error_radius, error_radius);
          end
          if (best_radius !== due.best_radius) begin
            $error("best_radius: expected %0d, got %0d", due.best_radius, best_radius);
          end
          if (locked !== due.locked) begin
            $error("locked: expected %0d, got %0d", due.locked, locked);
          end
        end
      end
      if (in_valid && in_ready) begin
        fix_reports_due.push_back(grade_fix(lon_sigma, lat_sigma));
      end
    end
    pending <= fix_reports_due.size();
  end

endmodule

### tb/sv/tb_gnss_error_quality_grader_top.sv
`timescale 1ns / 1ps

module tb_gnss_error_quality_grader_top;
  import gqg_pkg::*;

  localparam int SW = SIGMA_WIDTH_DEFAULT;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [SW-1:0]          lon_sigma;
  logic [SW-1:0]          lat_sigma;
  logic                   out_valid;
  logic                   out_ready;
  logic [GRADE_W-1:0]     grade;
  logic [REG_W-1:0]       error_radius;
  logic [REG_W-1:0]       best_radius;
  logic                   locked;
  int                     fail_count;
  int                     pending;
  bit                     idle_on;

  gnss_error_quality_grader_top #(.SIGMA_WIDTH(SW)) dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .lon_sigma(lon_sigma), .lat_sigma(lat_sigma),
    .out_valid(out_valid), .out_ready(out_ready),
    .grade(grade), .error_radius(error_radius), .best_radius(best_radius),
    .locked(locked)
  );

  gnss_error_quality_grader_checker #(.SIGMA_WIDTH(SW)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .lon_sigma(lon_sigma), .lat_sigma(lat_sigma),
    .out_valid(out_valid), .out_ready(out_ready),
    .grade(grade), .error_radius(error_radius), .best_radius(best_radius),
    .locked(locked),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= !(idle_on && $urandom_range(0, 99) < 9);
    end
  end

  task automatic send_fix(input logic [SW-1:0] lon, input logic [SW-1:0] lat);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    lon_sigma <= lon;
    lat_sigma <= lat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_limits(input logic [REG_W-1:0] thr, input logic [REG_W-1:0] clamp);
    cfg_wen <= 1'b1;
    cfg_index <= REG_LOCK_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_index <= REG_CLAMP_LIMIT;
    cfg_data <= clamp;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= REG_W'($urandom);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Most pairs land between one and about thirty times the base radius so that
  // every grade band is hit; the rest are zeros and full-range noise.
  task automatic send_random(input int count, input int base);
    int            pick;
    int            t;
    logic [SW-1:0] lon;
    logic [SW-1:0] lat;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        lon = '0;
        lat = '0;
      end else if (pick < 25) begin
        lon = SW'($urandom);
        lat = SW'($urandom);
      end else if (pick < 30) begin
        lon = SW'($urandom);
        lat = '0;
      end else begin
        t = base * $urandom_range(100, 3000) / 100;
        if (t > 65535) begin
          t = 65535;
        end
        lon = SW'(t);
        lat = SW'($urandom_range(0, t / 2));
      end
      if ($urandom_range(0, 1) == 1) begin
        send_fix(lat, lon);
      end else begin
        send_fix(lon, lat);
      end
    end
  endtask

  initial begin
    idle_on = 1'b1;
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= REG_LOCK_THRESHOLD;
    cfg_data <= '0;
    in_valid <= 1'b0;
    lon_sigma <= '0;
    lat_sigma <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A zero threshold keeps the grader unlocked throughout.
    set_limits(15'd0, 15'd32767);
    send_random(60, 2000);
    drain();

    set_limits(LOCK_THRESHOLD_RESET, CLAMP_LIMIT_RESET);
    send_fix(16'd0, 16'd0);
    send_fix(16'hFFFF, 16'hFFFF);
    send_fix(16'd0, 16'd0);
    send_fix(16'd25344, 16'd0);
    send_fix(16'd0, 16'd25343);
    send_fix(16'hAAAA, 16'h5555);
    send_fix(16'h5555, 16'hAAAA);
    send_fix(16'd2560, 16'd0);
    send_fix(16'd1536, 16'd2048);
    send_fix(16'd600, 16'd800);
    send_fix(16'd0, 16'd0);
    send_fix(16'd1499, 16'd0);
    send_fix(16'd1500, 16'd0);
    send_fix(16'd0, 16'd3999);
    send_fix(16'd4000, 16'd0);
    send_fix(16'd7999, 16'd0);
    send_fix(16'd0, 16'd8000);
    send_fix(16'd19999, 16'd0);
    send_fix(16'd20000, 16'd0);
    send_fix(16'hFFFF, 16'd0);
    send_fix(16'd900, 16'd0);
    drain();

    set_limits(15'd25344, 15'd32767);
    send_random(250, 900);
    drain();

    idle_on = 1'b0;
    set_limits(REG_W'($urandom_range(0, 25344)), REG_W'($urandom_range(256, 32767)));
    send_random(250, 900);
    drain();

    idle_on = 1'b1;
    set_limits(15'd0, 15'd256);
    send_random(100, 256);
    drain();

    set_limits(LOCK_THRESHOLD_RESET, CLAMP_LIMIT_RESET);
    send_random(150, 256);
    send_fix(16'd1, 16'd0);
    send_fix(16'd0, 16'd1);
    send_fix(16'd1, 16'd1);
    send_fix(16'hFFFF, 16'hFFFF);
    drain();

    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
